// ----- rtl/core/mtoc_pkg.sv -----
// Shared constants for the median threshold onset capture block.
package mtoc_pkg;

   localparam int WINDOW = 4096;
   localparam int WIN_AW = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W = 4;
   localparam int LEN_W = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_LENGTH = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;
   localparam logic [LEN_W-1:0] CAPTURE_RESET = 12'd500;
   localparam logic [LEN_W-1:0] SKIP_RESET = 12'd1401;

endpackage

// ----- rtl/core/mtoc_if.sv -----
// Valid/ready channel interfaces for samples and results.
interface mtoc_req_if;
   logic valid;
   logic ready;
   logic signed [mtoc_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
   modport monitor (input valid, input sample, input ready);
endinterface

interface mtoc_rsp_if;
   logic valid;
   logic ready;
   logic [mtoc_pkg::SAMPLE_W-1:0] captured_value;
   logic onset;
   logic capturing;

   modport source (output valid, output captured_value, output onset, output capturing,
                   input ready);
   modport sink (input valid, input captured_value, input onset, input capturing,
                 output ready);
   modport monitor (input valid, input captured_value, input onset, input capturing,
                    input ready);
endinterface

// ----- rtl/core/mtoc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mtoc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/core/median_threshold_onset_capture_top.sv -----
// Top level of the running median threshold onset detector with capture.
//
//   channel   direction  word
//   req_bus   in         sample (signed 16 bits)
//   rsp_bus   out        captured_value (16), onset (1), capturing (1)
//   csr_*     in         write enable, register index, 12-bit data
//
// The single read port of the sorted-window RAM paces each word: one entry per cycle
// during the search for the oldest value (once the window is full) and the shift that
// reinserts the new one; no new sample is taken until the block is idle again. The
// result word is registered in the decide state once the output register is free; a
// stalled result only holds the block before its next decision. Reset is synchronous
// and needs no clearing pass, as only written entries of the RAMs are ever used.
module median_threshold_onset_capture_top (
   input  logic                                   clock,
   input  logic                                   reset,
   mtoc_req_if.sink                               req_bus,
   mtoc_rsp_if.source                             rsp_bus,
   input  logic                                   csr_we,
   input  logic [mtoc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mtoc_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int AW = mtoc_pkg::WIN_AW;
   localparam int FW = mtoc_pkg::FILL_W;
   localparam int SW = mtoc_pkg::SAMPLE_W;
   localparam int LW = mtoc_pkg::LEN_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(mtoc_pkg::WINDOW - 1);
   localparam logic [FW-1:0] WIN_FILL = FW'(mtoc_pkg::WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_SEARCH, ST_UP, ST_DOWN
   } state_type;

   typedef enum logic [1:0] {
      PH_DETECT, PH_CAPTURE, PH_SKIP
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [LW-1:0] phase_count_ff, phase_count_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] ring_ptr_ff, ring_ptr_in;
   logic [AW-1:0] k_ff, k_in;
   logic [SW-1:0] a_ff, a_in;
   logic [SW-1:0] old_ff, old_in;

   logic [mtoc_pkg::GAIN_W-1:0] gain_ff;
   logic [LW-1:0] capture_len_ff;
   logic [LW-1:0] skip_len_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_onset_ff, rsp_onset_in;
   logic rsp_cap_ff, rsp_cap_in;

   logic srt_wr_en, srt_rd_en, ring_wr_en, ring_rd_en;
   logic [AW-1:0] srt_wr_addr, srt_rd_addr, ring_rd_addr;
   logic [SW-1:0] srt_wr_data, srt_rd_data, ring_rd_data;

   logic accept, out_free;
   logic [SW-1:0] raw_abs;
   logic [SW+mtoc_pkg::GAIN_W-1:0] product;
   logic [SW-1:0] threshold;
   logic [LW-1:0] run_len, count_dec;

   mtoc_ram #(.WIDTH(SW), .DEPTH(mtoc_pkg::WINDOW)) u_sorted (
      .clock   (clock),
      .wr_en   (srt_wr_en),
      .wr_addr (srt_wr_addr),
      .wr_data (srt_wr_data),
      .rd_en   (srt_rd_en),
      .rd_addr (srt_rd_addr),
      .rd_data (srt_rd_data)
   );

   mtoc_ram #(.WIDTH(SW), .DEPTH(mtoc_pkg::WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_ptr_ff),
      .wr_data (a_ff),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.captured_value = rsp_value_ff;
   assign rsp_bus.onset = rsp_onset_ff;
   assign rsp_bus.capturing = rsp_cap_ff;

   // Two's complement negate; the most negative sample maps to 0x8000.
   assign raw_abs = req_bus.sample[SW-1] ? SW'(-req_bus.sample) : req_bus.sample;
   assign product = gain_ff * srt_rd_data;
   assign threshold = product[SW-1:0];
   assign run_len = (capture_len_ff == '0) ? LW'(1) : capture_len_ff;
   assign count_dec = (phase_count_ff != '0) ? phase_count_ff - LW'(1) : '0;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      phase_count_in = phase_count_ff;
      fill_in = fill_ff;
      ring_ptr_in = ring_ptr_ff;
      k_in = k_ff;
      a_in = a_ff;
      old_in = old_ff;
      rsp_valid_in = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_onset_in = rsp_onset_ff;
      rsp_cap_in = rsp_cap_ff;
      srt_wr_en = 1'b0;
      srt_wr_addr = k_ff;
      srt_wr_data = a_ff;
      srt_rd_en = 1'b0;
      srt_rd_addr = k_ff;
      ring_wr_en = 1'b0;
      ring_rd_en = 1'b0;
      ring_rd_addr = ring_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in = raw_abs;
               srt_rd_en = 1'b1;
               srt_rd_addr = AW'(fill_ff >> 1);
               ring_rd_en = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_onset_in = 1'b0;
               rsp_cap_in = 1'b0;
               unique case (phase_ff)
                  PH_DETECT: begin
                     if (fill_ff != '0 && a_ff > threshold) begin
                        rsp_value_in = a_ff;
                        rsp_onset_in = 1'b1;
                        rsp_cap_in = 1'b1;
                        if (run_len > LW'(1)) begin
                           phase_in = PH_CAPTURE;
                           phase_count_in = run_len - LW'(1);
                        end else if (skip_len_ff != '0) begin
                           phase_in = PH_SKIP;
                           phase_count_in = skip_len_ff;
                        end else begin
                           phase_in = PH_DETECT;
                           phase_count_in = '0;
                        end
                     end
                  end
                  PH_CAPTURE: begin
                     rsp_value_in = a_ff;
                     rsp_cap_in = 1'b1;
                     phase_count_in = count_dec;
                     if (count_dec == '0) begin
                        if (skip_len_ff != '0) begin
                           phase_in = PH_SKIP;
                           phase_count_in = skip_len_ff;
                        end else begin
                           phase_in = PH_DETECT;
                        end
                     end
                  end
                  default: begin
                     phase_count_in = count_dec;
                     if (count_dec == '0) begin
                        phase_in = PH_DETECT;
                     end
                  end
               endcase

               old_in = ring_rd_data;
               ring_wr_en = 1'b1;
               ring_ptr_in = (ring_ptr_ff == LAST_ADDR) ? '0 : ring_ptr_ff + AW'(1);
               if (fill_ff < WIN_FILL) begin
                  fill_in = fill_ff + FW'(1);
                  k_in = fill_ff[AW-1:0];
                  if (fill_ff == '0) begin
                     srt_wr_en = 1'b1;
                     srt_wr_addr = '0;
                     state_in = ST_IDLE;
                  end else begin
                     srt_rd_en = 1'b1;
                     srt_rd_addr = fill_ff[AW-1:0] - AW'(1);
                     state_in = ST_DOWN;
                  end
               end else begin
                  k_in = '0;
                  srt_rd_en = 1'b1;
                  srt_rd_addr = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            // Read data belongs to entry k; the read for k + 1, or k - 1 when turning down, goes out in parallel.
            srt_rd_en = 1'b1;
            srt_rd_addr = k_ff + AW'(1);
            if (k_ff != LAST_ADDR && srt_rd_data != old_ff) begin
               k_in = k_ff + AW'(1);
            end else if (a_ff > old_ff) begin
               state_in = ST_UP;
            end else begin
               srt_rd_addr = k_ff - AW'(1);
               state_in = ST_DOWN;
            end
         end
         ST_UP: begin
            if (k_ff != LAST_ADDR && srt_rd_data < a_ff) begin
               srt_wr_en = 1'b1;
               srt_wr_data = srt_rd_data;
               k_in = k_ff + AW'(1);
               srt_rd_en = 1'b1;
               srt_rd_addr = k_ff + AW'(2);
            end else begin
               srt_wr_en = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DOWN: begin
            if (k_ff != '0 && srt_rd_data > a_ff) begin
               srt_wr_en = 1'b1;
               srt_wr_data = srt_rd_data;
               k_in = k_ff - AW'(1);
               srt_rd_en = 1'b1;
               srt_rd_addr = k_ff - AW'(2);
            end else begin
               srt_wr_en = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DETECT;
         phase_count_ff <= '0;
         fill_ff <= '0;
         ring_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         gain_ff <= mtoc_pkg::GAIN_RESET;
         capture_len_ff <= mtoc_pkg::CAPTURE_RESET;
         skip_len_ff <= mtoc_pkg::SKIP_RESET;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         phase_count_ff <= phase_count_in;
         fill_ff <= fill_in;
         ring_ptr_ff <= ring_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               mtoc_pkg::CSR_THRESHOLD_GAIN: gain_ff <= csr_data[mtoc_pkg::GAIN_W-1:0];
               mtoc_pkg::CSR_CAPTURE_LENGTH: capture_len_ff <= csr_data[LW-1:0];
               mtoc_pkg::CSR_SKIP_LENGTH: skip_len_ff <= csr_data[LW-1:0];
               default: begin
               end
            endcase
         end
      end
      k_ff <= k_in;
      a_ff <= a_in;
      old_ff <= old_in;
      rsp_value_ff <= rsp_value_in;
      rsp_onset_ff <= rsp_onset_in;
      rsp_cap_ff <= rsp_cap_in;
   end

endmodule

// ----- rtl/core/mtoc_checker.sv -----
// Port-level checks for the onset capture block, bound to its top level.
module mtoc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mtoc_pkg::SAMPLE_W-1:0] rsp_value,
   input logic                          rsp_onset,
   input logic                          rsp_capturing
);

   // A result word waiting for the sink must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // An onset always opens a capture run.
   a_onset_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_onset |-> rsp_capturing)
      else $error("onset without capturing");

   // Outside a capture run the value is forced to zero.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_capturing |-> rsp_value == '0)
      else $error("nonzero value outside capture");

   // The block takes one sample at a time, so ready drops after each accepted word.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample accepted while busy");

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind median_threshold_onset_capture_top mtoc_checker u_mtoc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_value     (rsp_bus.captured_value),
   .rsp_onset     (rsp_bus.onset),
   .rsp_capturing (rsp_bus.capturing)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the median threshold onset capture block.
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_HALF = 5;
   localparam int WINDOW = mtoc_pkg::WINDOW;
   localparam int SAMPLE_W = mtoc_pkg::SAMPLE_W;
   localparam int GAIN_W = mtoc_pkg::GAIN_W;
   localparam int CSR_IDX_W = mtoc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = mtoc_pkg::CSR_DATA_W;
   localparam int DRAIN_WAIT = WINDOW + 16;
   localparam longint CYCLE_LIMIT = 64'd2_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {DETECTING, CAPTURING, SKIPPING} phase_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] captured_value;
      logic                onset;
      logic                capturing;
   } capture_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mtoc_req_if req_bus();
   mtoc_rsp_if rsp_bus();

   median_threshold_onset_capture_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow of the block's state and registers.
   logic [SAMPLE_W-1:0] win_sorted [WINDOW];
   logic [SAMPLE_W-1:0] win_ring [WINDOW];
   int unsigned win_fill;
   int unsigned win_ptr;
   phase_type run_phase;
   int unsigned run_count;
   int unsigned gain_reg;
   int unsigned capture_reg;
   int unsigned skip_reg;

   capture_word_type expected_words[$];
   int error_count = 0;
   longint cycle_count = 0;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   function automatic void end_of_capture();
      if (skip_reg > 0) begin
         run_phase = SKIPPING;
         run_count = skip_reg;
      end else begin
         run_phase = DETECTING;
         run_count = 0;
      end
   endfunction

   function automatic void push_window(logic [SAMPLE_W-1:0] a);
      int k;
      logic [SAMPLE_W-1:0] old;
      if (win_fill < WINDOW) begin
         k = win_fill;
         while (k > 0 && win_sorted[k-1] > a) begin
            win_sorted[k] = win_sorted[k-1];
            k--;
         end
         win_sorted[k] = a;
         win_fill++;
      end else begin
         old = win_ring[win_ptr];
         k = 0;
         while (k < WINDOW - 1 && win_sorted[k] != old) k++;
         if (a > old) begin
            while (k + 1 < WINDOW && win_sorted[k+1] < a) begin
               win_sorted[k] = win_sorted[k+1];
               k++;
            end
         end else begin
            while (k > 0 && win_sorted[k-1] > a) begin
               win_sorted[k] = win_sorted[k-1];
               k--;
            end
         end
         win_sorted[k] = a;
      end
      win_ring[win_ptr] = a;
      win_ptr = (win_ptr + 1) % WINDOW;
   endfunction

   function automatic capture_word_type predict_onset(logic [SAMPLE_W-1:0] raw);
      capture_word_type w;
      int unsigned a;
      int unsigned thr;
      int unsigned len;
      a = raw[SAMPLE_W-1] ? 32'h10000 - raw : raw;
      w = '0;
      case (run_phase)
         DETECTING: begin
            if (win_fill > 0) begin
               thr = (gain_reg * win_sorted[win_fill/2]) & 32'hFFFF;
               if (a > thr) begin
                  len = (capture_reg == 0) ? 1 : capture_reg;
                  w.captured_value = a[SAMPLE_W-1:0];
                  w.onset = 1'b1;
                  w.capturing = 1'b1;
                  if (len > 1) begin
                     run_phase = CAPTURING;
                     run_count = len - 1;
                  end else begin
                     end_of_capture();
                  end
               end
            end
         end
         CAPTURING: begin
            w.captured_value = a[SAMPLE_W-1:0];
            w.capturing = 1'b1;
            if (run_count > 0) run_count--;
            if (run_count == 0) end_of_capture();
         end
         default: begin
            if (run_count > 0) run_count--;
            if (run_count == 0) run_phase = DETECTING;
         end
      endcase
      push_window(a[SAMPLE_W-1:0]);
      return w;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mtoc_pkg::CSR_THRESHOLD_GAIN: gain_reg = value[GAIN_W-1:0];
         mtoc_pkg::CSR_CAPTURE_LENGTH: capture_reg = value;
         mtoc_pkg::CSR_SKIP_LENGTH:    skip_reg = value;
         default: ;
      endcase
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] raw);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= raw;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_words.push_back(predict_onset(raw));
   endtask

   // Lowers valid, then waits for every pending word and the block's tail latency.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int unsigned pick;
      logic [SAMPLE_W-1:0] mag;
      pick = $urandom_range(99);
      if (pick < 5) return SAMPLE_W'($urandom());
      mag = (pick < 20) ? SAMPLE_W'($urandom_range(32767, 2000))
                        : SAMPLE_W'($urandom_range(200));
      return $urandom_range(1) ? -mag : mag;
   endfunction

   task automatic test_directed_cases();
      // Ignored index first, then zero gain with the shortest run and no skip.
      write_csr(CSR_UNUSED, 12'hFFF);
      write_csr(mtoc_pkg::CSR_THRESHOLD_GAIN, 12'd0);
      write_csr(mtoc_pkg::CSR_CAPTURE_LENGTH, 12'd0);
      write_csr(mtoc_pkg::CSR_SKIP_LENGTH, 12'd0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_sample(16'sh7FFF);
      send_sample(16'sd1);
      send_sample(16'sd0);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      send_sample(16'sh7FFF);
      wait_idle();
      // Largest gain makes the product wrap to 16 bits.
      write_csr(mtoc_pkg::CSR_THRESHOLD_GAIN, 12'd15);
      write_csr(mtoc_pkg::CSR_CAPTURE_LENGTH, 12'd3);
      write_csr(mtoc_pkg::CSR_SKIP_LENGTH, 12'd2);
      send_sample(16'sh7FFF);
      send_sample(16'sh5555);
      send_sample(-16'sh2AAB);
      send_sample(16'sd3);
      // The sender holds off here until every pending word is back.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      send_sample(16'sh8000);
      send_sample(16'sd2);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sd0);
      wait_idle();
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      write_csr(mtoc_pkg::CSR_THRESHOLD_GAIN, CSR_DATA_W'($urandom_range(15, 1)));
      write_csr(mtoc_pkg::CSR_CAPTURE_LENGTH, CSR_DATA_W'($urandom_range(8, 1)));
      write_csr(mtoc_pkg::CSR_SKIP_LENGTH, CSR_DATA_W'($urandom_range(6)));
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_sample(random_sample());
      wait_idle();
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      capture_word_type exp_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: captured_value %0d onset %0b capturing %0b",
                   rsp_bus.captured_value, rsp_bus.onset, rsp_bus.capturing);
            error_count++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_bus.captured_value !== exp_w.captured_value) begin
               $error("captured_value: expected %0d, got %0d",
                      exp_w.captured_value, rsp_bus.captured_value);
               error_count++;
            end
            if (rsp_bus.onset !== exp_w.onset) begin
               $error("onset: expected %0b, got %0b", exp_w.onset, rsp_bus.onset);
               error_count++;
            end
            if (rsp_bus.capturing !== exp_w.capturing) begin
               $error("capturing: expected %0b, got %0b",
                      exp_w.capturing, rsp_bus.capturing);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      win_fill = 0;
      win_ptr = 0;
      run_phase = DETECTING;
      run_count = 0;
      gain_reg = mtoc_pkg::GAIN_RESET;
      capture_reg = mtoc_pkg::CAPTURE_RESET;
      skip_reg = mtoc_pkg::SKIP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_phase(0, 0, 25);
      test_random_phase(54, 0, 25);
      test_random_phase(0, 54, 25);
      test_random_phase(36, 36, 25);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mtoc_pkg.sv
rtl/core/mtoc_if.sv
rtl/core/mtoc_ram.sv
rtl/core/median_threshold_onset_capture_top.sv
rtl/core/mtoc_checker.sv
tb/tb_top.sv
